// ===== sv/stw_pkg.sv =====
`timescale 1ns / 1ps
// stw_pkg: types, constants and the sine table of the sine texture warp
// pixel generator; no dependencies

package stw_pkg;

  localparam int unsigned FRAME_WIDTH    = 320;
  localparam int unsigned FRAME_HEIGHT   = 200;
  localparam int unsigned SINE_AMPLITUDE = 7;

  localparam int unsigned COL_W   = 9;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned PHASE_W = 8;
  localparam int unsigned TEX_AW  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_IW  = 3;
  localparam int unsigned CFG_DW  = 8;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(FRAME_WIDTH - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(FRAME_HEIGHT - 1);

  typedef enum logic [CFG_IW-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_LINE_X  = 3'd2,
    REG_LINE_Y  = 3'd3,
    REG_PIX_X   = 3'd4,
    REG_PIX_Y   = 3'd5
  } reg_idx_e;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } item_kind_e;

  localparam logic [CFG_DW-1:0] START_X_RST = 8'd0;
  localparam logic [CFG_DW-1:0] START_Y_RST = 8'd0;
  localparam logic [CFG_DW-1:0] LINE_X_RST  = 8'd3;
  localparam logic [CFG_DW-1:0] LINE_Y_RST  = 8'd2;
  localparam logic [CFG_DW-1:0] PIX_X_RST   = 8'd4;
  localparam logic [CFG_DW-1:0] PIX_Y_RST   = 8'd5;

  typedef struct packed {
    logic              kind;
    logic [TEX_AW-1:0] load_address;
    logic [BYTE_W-1:0] load_byte;
  } stw_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel;
    logic [TEX_AW-1:0] fetch_address;
    logic              line_end;
    logic              frame_end;
  } stw_out_t;

  typedef logic [255:0][BYTE_W-1:0] sine_rom_t;

  // restoring shift-subtract quotient, used only while building the table
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // fixed-point quarter-wave taylor series, evaluated at elaboration
  function automatic sine_rom_t sine_rom_build();
    sine_rom_t         rom;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   sum;
    longint unsigned   k;
    int unsigned       h;
    int unsigned       q;
    logic [BYTE_W-1:0] mag;
    for (int unsigned i = 0; i < 256; i++) begin
      h = i & 127;
      q = (h <= 64) ? h : 128 - h;
      x = (64'd3373259426 * 64'(q)) >> 7;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (k = 1; k <= 8; k++) begin
        term = udiv64((term * x2) >> 30, (2 * k) * (2 * k + 1));
        if (k[0]) sum = (sum > term) ? sum - term : 64'd0;
        else sum = sum + term;
      end
      if (sum > (64'd1 << 30)) sum = 64'd1 << 30;
      mag = BYTE_W'((64'(SINE_AMPLITUDE) * sum + (64'd1 << 10)) >> 30);
      rom[8'(i)] = (i >= 128) ? BYTE_W'(8'd0 - mag) : mag;
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = sine_rom_build();

endpackage

// ===== sv/stw_if.sv =====
`timescale 1ns / 1ps
// stw_in_if / stw_out_if: valid-ready channels for items and results
// depends on stw_pkg

interface stw_in_if import stw_pkg::*; ();
  logic    valid;
  logic    ready;
  stw_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stw_out_if import stw_pkg::*; ();
  logic     valid;
  logic     ready;
  stw_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/sine_texture_warp_pixel_generator.sv =====
`timescale 1ns / 1ps
// sine_texture_warp_pixel_generator: sine-warped raster reader of a 256x256 texture
// depends on stw_pkg and stw_if
// a pixel item's result is registered and valid in the cycle after it is accepted
// throughput: one item per cycle while the output is not stalled, set by the single texture memory port
// reset clears counters, phases, config registers and the result valid flag;
// texture contents are not cleared

module sine_texture_warp_pixel_generator import stw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  stw_in_if.sink            in_i,
  stw_out_if.source         out_o
);

  logic [CFG_DW-1:0] start_x_q, start_y_q, line_x_q, line_y_q, pix_x_q, pix_y_q;

  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [PHASE_W-1:0] outer_x_q, outer_x_d, outer_y_q, outer_y_d;
  logic [PHASE_W-1:0] inner_x_q, inner_x_d, inner_y_q, inner_y_d;
  logic               valid_q, valid_d;

  logic [TEX_AW-1:0]  addr_q;
  logic               line_end_q, frame_end_q;
  logic [BYTE_W-1:0]  pix_q;

  logic               accept, pix_acc, load_acc;
  logic               line_start, frame_start, line_end, frame_end;
  logic [PHASE_W-1:0] ox_base, oy_base, ox_new, oy_new, ix_cur, iy_cur;
  logic [BYTE_W-1:0]  sx, sy;
  logic [7:0]         tex_row, tex_col;
  logic [TEX_AW-1:0]  fetch_addr;

  logic [BYTE_W-1:0]  tex_mem [2**TEX_AW];

  assign in_i.ready = !valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign pix_acc    = accept && (in_i.data.kind == KIND_PIXEL);
  assign load_acc   = accept && (in_i.data.kind == KIND_LOAD);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= START_X_RST;
      start_y_q <= START_Y_RST;
      line_x_q  <= LINE_X_RST;
      line_y_q  <= LINE_Y_RST;
      pix_x_q   <= PIX_X_RST;
      pix_y_q   <= PIX_Y_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_START_X: start_x_q <= cfg_data_i;
        REG_START_Y: start_y_q <= cfg_data_i;
        REG_LINE_X:  line_x_q  <= cfg_data_i;
        REG_LINE_Y:  line_y_q  <= cfg_data_i;
        REG_PIX_X:   pix_x_q   <= cfg_data_i;
        REG_PIX_Y:   pix_y_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // phase, address and next-state computation
  always_comb begin
    line_start  = (col_q == '0);
    frame_start = line_start && (row_q == '0);
    ox_base     = frame_start ? start_x_q : outer_x_q;
    oy_base     = frame_start ? start_y_q : outer_y_q;
    ox_new      = ox_base + line_x_q;
    oy_new      = oy_base + line_y_q;
    ix_cur      = line_start ? ox_new : inner_x_q;
    iy_cur      = line_start ? oy_new : inner_y_q;
    sx          = SINE_ROM[ix_cur];
    sy          = SINE_ROM[iy_cur];
    tex_row     = row_q + sy;
    tex_col     = col_q[7:0] + sx;
    fetch_addr  = {tex_row, tex_col};
    line_end    = (col_q == LAST_COL);
    frame_end   = line_end && (row_q == LAST_ROW);

    col_d     = col_q;
    row_d     = row_q;
    outer_x_d = outer_x_q;
    outer_y_d = outer_y_q;
    inner_x_d = inner_x_q;
    inner_y_d = inner_y_q;
    if (pix_acc) begin
      if (line_start) begin
        outer_x_d = ox_new;
        outer_y_d = oy_new;
      end
      inner_x_d = ix_cur + pix_x_q;
      inner_y_d = iy_cur + pix_y_q;
      col_d     = line_end ? '0 : col_q + 1'b1;
      if (line_end) row_d = frame_end ? '0 : row_q + 1'b1;
    end

    if (accept) valid_d = pix_acc;
    else if (out_o.ready) valid_d = 1'b0;
    else valid_d = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      outer_x_q <= START_X_RST;
      outer_y_q <= START_Y_RST;
      inner_x_q <= '0;
      inner_y_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      outer_x_q <= outer_x_d;
      outer_y_q <= outer_y_d;
      inner_x_q <= inner_x_d;
      inner_y_q <= inner_y_d;
      valid_q   <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      addr_q      <= fetch_addr;
      line_end_q  <= line_end;
      frame_end_q <= frame_end;
    end
  end

  // texture memory
  always_ff @(posedge clk_i) begin
    if (load_acc) tex_mem[in_i.data.load_address] <= in_i.data.load_byte;
    if (pix_acc) pix_q <= tex_mem[fetch_addr];
  end

  assign out_o.valid              = valid_q;
  assign out_o.data.pixel         = pix_q;
  assign out_o.data.fetch_address = addr_q;
  assign out_o.data.line_end      = line_end_q;
  assign out_o.data.frame_end     = frame_end_q;

endmodule

// ===== dv/stw_pixel_checker.sv =====
`timescale 1ns / 1ps
// stw_pixel_checker: watches the config port and both item channels, predicts each warped
// pixel and compares it field by field; depends on stw_pkg and stw_if

module stw_pixel_checker import stw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  stw_in_if                 in_i,
  stw_out_if                out_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o,
  output int unsigned       pixels_o,
  output int unsigned       lines_o,
  output int unsigned       frames_o
);

  localparam real HALF_TURN = 3.14159265358979323846;

  logic [BYTE_W-1:0]  texture_bytes [1 << TEX_AW];
  logic [BYTE_W-1:0]  sine_lut [256];
  stw_out_t           warped_pixels_due [$];

  logic [CFG_DW-1:0]  start_x, start_y, line_x, line_y, step_x, step_y;
  logic [COL_W-1:0]   col_cnt;
  logic [ROW_W-1:0]   row_cnt;
  logic [PHASE_W-1:0] outer_x, outer_y, inner_x, inner_y;
  int unsigned        mismatch_count;
  int unsigned        pixel_count, line_count, frame_count;

  function automatic logic [BYTE_W-1:0] sine_entry(input int unsigned i);
    int unsigned h;
    int unsigned q;
    int          mag;
    h = i % 128;
    q = (h <= 64) ? h : 128 - h;
    mag = $rtoi(real'(SINE_AMPLITUDE) * $sin(HALF_TURN * real'(q) / 128.0) + 1.0e-9);
    return (i >= 128) ? BYTE_W'(-mag) : BYTE_W'(mag);
  endfunction

  initial begin
    for (int unsigned i = 0; i < 256; i++) sine_lut[i] = sine_entry(i);
  end

  function automatic stw_out_t warp_next_pixel();
    stw_out_t    res;
    logic [7:0]  row_a;
    logic [7:0]  col_a;
    int unsigned next_col;
    int unsigned next_row;
    if (col_cnt == '0) begin
      if (row_cnt == '0) begin
        outer_x = start_x;
        outer_y = start_y;
      end
      outer_x = outer_x + line_x;
      outer_y = outer_y + line_y;
      inner_x = outer_x;
      inner_y = outer_y;
    end
    row_a = row_cnt + sine_lut[inner_y];
    col_a = col_cnt[7:0] + sine_lut[inner_x];
    res.fetch_address = {row_a, col_a};
    res.pixel = texture_bytes[{row_a, col_a}];
    res.line_end = 1'b0;
    res.frame_end = 1'b0;
    inner_x = inner_x + step_x;
    inner_y = inner_y + step_y;
    next_col = (int'(col_cnt) + 1) % 512;
    if (next_col >= FRAME_WIDTH || next_col == 0) begin
      col_cnt = '0;
      res.line_end = 1'b1;
      next_row = (int'(row_cnt) + 1) % 256;
      if (next_row >= FRAME_HEIGHT || next_row == 0) begin
        row_cnt = '0;
        res.frame_end = 1'b1;
      end else begin
        row_cnt = ROW_W'(next_row);
      end
    end else begin
      col_cnt = COL_W'(next_col);
    end
    return res;
  endfunction

  task automatic check_pixel(input stw_out_t got);
    stw_out_t want;
    if (warped_pixels_due.size() == 0) begin
      $error("pixel result with no item outstanding: fetch_address %h", got.fetch_address);
      mismatch_count++;
      return;
    end
    want = warped_pixels_due.pop_front();
    if (got.pixel !== want.pixel) begin
      $error("pixel: expected %h, got %h", want.pixel, got.pixel);
      mismatch_count++;
    end
    if (got.fetch_address !== want.fetch_address) begin
      $error("fetch_address: expected %h, got %h", want.fetch_address, got.fetch_address);
      mismatch_count++;
    end
    if (got.line_end !== want.line_end) begin
      $error("line_end: expected %b, got %b", want.line_end, got.line_end);
      mismatch_count++;
    end
    if (got.frame_end !== want.frame_end) begin
      $error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
      mismatch_count++;
    end
    pixel_count++;
    if (got.line_end === 1'b1) line_count++;
    if (got.frame_end === 1'b1) frame_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x = START_X_RST;
      start_y = START_Y_RST;
      line_x = LINE_X_RST;
      line_y = LINE_Y_RST;
      step_x = PIX_X_RST;
      step_y = PIX_Y_RST;
      col_cnt = '0;
      row_cnt = '0;
      outer_x = START_X_RST;
      outer_y = START_Y_RST;
      inner_x = '0;
      inner_y = '0;
      mismatch_count = 0;
      pixel_count = 0;
      line_count = 0;
      frame_count = 0;
      warped_pixels_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_START_X: start_x = cfg_data_i;
          REG_START_Y: start_y = cfg_data_i;
          REG_LINE_X:  line_x = cfg_data_i;
          REG_LINE_Y:  line_y = cfg_data_i;
          REG_PIX_X:   step_x = cfg_data_i;
          REG_PIX_Y:   step_y = cfg_data_i;
          default: ;
        endcase
      end
      if (out_i.valid && out_i.ready) check_pixel(out_i.data);
      if (in_i.valid && in_i.ready) begin
        if (in_i.data.kind == KIND_LOAD) begin
          texture_bytes[in_i.data.load_address] = in_i.data.load_byte;
        end else begin
          warped_pixels_due.push_back(warp_next_pixel());
        end
      end
    end
    errors_o <= mismatch_count;
    pending_o <= warped_pixels_due.size();
    pixels_o <= pixel_count;
    lines_o <= line_count;
    frames_o <= frame_count;
  end

endmodule

// ===== dv/sine_texture_warp_pixel_generator_test.sv =====
`timescale 1ns / 1ps
// sine_texture_warp_pixel_generator_test: stimulus and verdict for the warp pixel generator
// depends on stw_pkg, stw_if, the block and stw_pixel_checker

module sine_texture_warp_pixel_generator_test;
  import stw_pkg::*;

  localparam logic [CFG_IW-1:0] REG_SPARE_6 = CFG_IW'(6);
  localparam logic [CFG_IW-1:0] REG_SPARE_7 = CFG_IW'(7);

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_index_i;
  logic [CFG_DW-1:0] cfg_data_i;

  int unsigned       mismatches, outstanding, pixels_seen, lines_seen, frames_seen;
  int unsigned       src_idle_pct, snk_idle_pct;
  longint unsigned   pixels_sent, loads_sent;

  // shadow of the registers and raster position, used to pick texture loads
  logic [CFG_DW-1:0]  sh_start_x, sh_start_y, sh_line_x, sh_line_y, sh_pix_x, sh_pix_y;
  logic [COL_W-1:0]   ras_col;
  logic [ROW_W-1:0]   ras_row;
  logic [PHASE_W-1:0] ras_ox, ras_oy, ras_ix, ras_iy;
  bit                 tex_written [1 << TEX_AW];

  stw_in_if  in_ch ();
  stw_out_if out_ch ();

  sine_texture_warp_pixel_generator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  stw_pixel_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_i      (out_ch),
    .errors_o   (mismatches),
    .pending_o  (outstanding),
    .pixels_o   (pixels_seen),
    .lines_o    (lines_seen),
    .frames_o   (frames_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic send_item(input stw_in_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= item;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (item.kind == KIND_PIXEL) pixels_sent++;
    else loads_sent++;
  endtask

  task automatic drain(input int unsigned max_cycles);
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0 && waited < max_cycles) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_START_X: sh_start_x = val;
      REG_START_Y: sh_start_y = val;
      REG_LINE_X:  sh_line_x = val;
      REG_LINE_Y:  sh_line_y = val;
      REG_PIX_X:   sh_pix_x = val;
      REG_PIX_Y:   sh_pix_y = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CFG_DW-1:0] sx, sy, lx, ly, px, py);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_LINE_X, lx);
    write_reg(REG_LINE_Y, ly);
    write_reg(REG_PIX_X, px);
    write_reg(REG_PIX_Y, py);
    // spare indexes must leave every register alone
    write_reg(REG_SPARE_6, CFG_DW'($urandom));
    write_reg(REG_SPARE_7, CFG_DW'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_random_regs();
    program_regs(CFG_DW'($urandom), CFG_DW'($urandom), CFG_DW'($urandom),
                 CFG_DW'($urandom), CFG_DW'($urandom), CFG_DW'($urandom));
  endtask

  // warped address of the next pixel, then advance the raster position
  task automatic raster_step(output logic [TEX_AW-1:0] addr);
    logic [7:0] r;
    logic [7:0] c;
    if (ras_col == '0) begin
      if (ras_row == '0) begin
        ras_ox = sh_start_x;
        ras_oy = sh_start_y;
      end
      ras_ox = ras_ox + sh_line_x;
      ras_oy = ras_oy + sh_line_y;
      ras_ix = ras_ox;
      ras_iy = ras_oy;
    end
    r = ras_row + SINE_ROM[ras_iy];
    c = ras_col[7:0] + SINE_ROM[ras_ix];
    addr = {r, c};
    ras_ix = ras_ix + sh_pix_x;
    ras_iy = ras_iy + sh_pix_y;
    if (ras_col == LAST_COL) begin
      ras_col = '0;
      ras_row = (ras_row == LAST_ROW) ? '0 : ras_row + 1'b1;
    end else begin
      ras_col = ras_col + 1'b1;
    end
  endtask

  task automatic send_load(input logic [TEX_AW-1:0] addr);
    tex_written[addr] = 1'b1;
    send_item(stw_in_t'{kind: KIND_LOAD, load_address: addr, load_byte: BYTE_W'($urandom)});
  endtask

  // the byte a pixel reads is always written before the pixel item goes out
  task automatic send_pixel();
    logic [TEX_AW-1:0] addr;
    raster_step(addr);
    if (!tex_written[addr] || $urandom_range(4) == 0) send_load(addr);
    send_item(stw_in_t'{kind: KIND_PIXEL, load_address: TEX_AW'($urandom),
                        load_byte: BYTE_W'($urandom)});
  endtask

  task automatic run_random(input int unsigned count, input int unsigned pixel_pct);
    longint unsigned stop;
    stop = pixels_sent + loads_sent + count;
    while (pixels_sent + loads_sent < stop) begin
      if ($urandom_range(149) == 0) drain(5000);
      if ($urandom_range(99) < pixel_pct) send_pixel();
      else send_load(TEX_AW'($urandom));
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= REG_START_X;
    cfg_data_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    src_idle_pct = 10;
    snk_idle_pct = 72;
    pixels_sent = 0;
    loads_sent = 0;
    sh_start_x = START_X_RST;
    sh_start_y = START_Y_RST;
    sh_line_x = LINE_X_RST;
    sh_line_y = LINE_Y_RST;
    sh_pix_x = PIX_X_RST;
    sh_pix_y = PIX_Y_RST;
    ras_col = '0;
    ras_row = '0;
    ras_ox = START_X_RST;
    ras_oy = START_Y_RST;
    ras_ix = '0;
    ras_iy = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_load(16'h0000);
    send_load(16'hffff);
    send_load(16'h00ff);
    send_load(16'hff00);
    repeat (10) send_pixel();
    drain(5000);

    program_random_regs();
    run_random(380, 85);
    drain(5000);

    src_idle_pct = 72;
    snk_idle_pct = 10;
    program_regs('1, '1, '1, '1, '1, '1);
    run_random(380, 85);
    drain(5000);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    program_random_regs();
    run_random(380, 90);
    drain(5000);

    $display("run covered %0d texture loads and %0d pixel items, %0d results checked",
             loads_sent, pixels_sent, pixels_seen);
    $display("%0d line ends and %0d frame ends seen over three idle mixes",
             lines_seen, frames_seen);
    if (outstanding != 0) $error("%0d pixel results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/stw_pkg.sv
sv/stw_if.sv
sv/sine_texture_warp_pixel_generator.sv
dv/stw_pixel_checker.sv
dv/sine_texture_warp_pixel_generator_test.sv
